// File: src/assert_macros.svh
// Assertion helpers for the upload sender; included by ufu_burst.
// Each macro expands to one labeled concurrent assertion on a rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ufu_pkg.sv
// Shared types, codes and helpers for the firmware upload sender.
// No dependencies; used by ufu_core, ufu_burst and the top level.
`timescale 1ns / 1ps

package ufu_pkg;

    localparam int MAX_RESULTS = 5;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int POS_W       = $clog2(MAX_RESULTS);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // link commands
    localparam logic [7:0] LINK_CONNECT = 8'hAA;
    localparam logic [7:0] LINK_INFO    = 8'hBB;
    localparam logic [7:0] LINK_DATA    = 8'hCC;
    localparam logic [7:0] LINK_END     = 8'hDD;

    // input opcodes
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_PAYLOAD = 2'd1;
    localparam logic [1:0] OP_REPLY   = 2'd2;
    localparam logic [1:0] OP_TICK    = 2'd3;

    // result status
    localparam logic [1:0] ST_RUNNING = 2'd0;
    localparam logic [1:0] ST_SUCCESS = 2'd1;
    localparam logic [1:0] ST_FAILED  = 2'd2;

    // failing stage
    localparam logic [2:0] STG_NONE    = 3'd0;
    localparam logic [2:0] STG_CONNECT = 3'd1;
    localparam logic [2:0] STG_ERASE   = 3'd2;
    localparam logic [2:0] STG_CHUNK   = 3'd3;
    localparam logic [2:0] STG_END     = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACK_CODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONNECT_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ERASE_TIMEOUT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PACKET_TIMEOUT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_TIMEOUT     = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE         = 3'd0,
        PH_WAIT_CONNECT = 3'd1,
        PH_WAIT_ERASE   = 3'd2,
        PH_DATA         = 3'd3,
        PH_WAIT_CHUNK   = 3'd4,
        PH_WAIT_END     = 3'd5,
        PH_DONE         = 3'd6,
        PH_FAILED       = 3'd7
    } phase_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] image_length;
        logic [7:0]  payload_byte;
        logic [7:0]  reply_byte;
    } in_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [1:0] status;
        logic [2:0] fail_stage;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [7:0]  ack_code;
        logic [15:0] connect_timeout;
        logic [15:0] erase_timeout;
        logic [15:0] packet_timeout;
        logic [15:0] end_timeout;
    } cfg_t;

    // one item's worth of results, handed from the core to the burst stage
    typedef struct packed {
        logic [CNT_W-1:0]             count;
        out_t [MAX_RESULTS-1:0]       res;
    } burst_t;

    function automatic out_t tx_res(input logic [7:0] b);
        out_t r;
        r.tx_valid   = 1'b1;
        r.tx_byte    = b;
        r.status     = ST_RUNNING;
        r.fail_stage = STG_NONE;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic out_t status_res(input logic [1:0] st, input logic [2:0] stg);
        out_t r;
        r.tx_valid   = 1'b0;
        r.tx_byte    = 8'd0;
        r.status     = st;
        r.fail_stage = stg;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

// File: src/ufu_core.sv
// Upload protocol state and per-item result generation.
// Depends on ufu_pkg; feeds a burst of results to ufu_burst.
`timescale 1ns / 1ps

module ufu_core #(
    parameter int CHUNK_SIZE = 128
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  ufu_pkg::in_t    item,
    input  ufu_pkg::cfg_t   cfg,
    output ufu_pkg::burst_t burst
);
    import ufu_pkg::*;

    localparam logic [31:0] CHUNK_LEN = 32'(CHUNK_SIZE);

    phase_t      phase_reg, phase_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [7:0]  frame_size_reg, frame_size_next;
    logic [7:0]  chunk_cnt_reg, chunk_cnt_next;
    logic [7:0]  chunk_xor_reg, chunk_xor_next;
    logic [7:0]  image_xor_reg, image_xor_next;
    logic [15:0] timer_reg, timer_next;

    logic        waiting;
    logic [2:0]  stage;
    logic [7:0]  frame_len;
    logic [7:0]  cnt_inc;
    logic [7:0]  xor_inc;

    always_comb begin
        waiting = (phase_reg == PH_WAIT_CONNECT) || (phase_reg == PH_WAIT_ERASE) ||
                  (phase_reg == PH_WAIT_CHUNK) || (phase_reg == PH_WAIT_END);
        case (phase_reg)
            PH_WAIT_CONNECT: stage = STG_CONNECT;
            PH_WAIT_ERASE:   stage = STG_ERASE;
            PH_WAIT_CHUNK:   stage = STG_CHUNK;
            PH_WAIT_END:     stage = STG_END;
            default:         stage = STG_NONE;
        endcase
        frame_len = (remaining_reg > CHUNK_LEN) ? CHUNK_LEN[7:0] : remaining_reg[7:0];
        cnt_inc   = chunk_cnt_reg + 8'd1;
        xor_inc   = chunk_xor_reg ^ item.payload_byte;
    end

    always_comb begin
        phase_next      = phase_reg;
        remaining_next  = remaining_reg;
        frame_size_next = frame_size_reg;
        chunk_cnt_next  = chunk_cnt_reg;
        chunk_xor_next  = chunk_xor_reg;
        image_xor_next  = image_xor_reg;
        timer_next      = timer_reg;
        burst           = '0;

        if (accept) begin
            case (item.opcode)
                OP_START: begin
                    remaining_next  = item.image_length;
                    frame_size_next = 8'd0;
                    chunk_cnt_next  = 8'd0;
                    chunk_xor_next  = 8'd0;
                    image_xor_next  = 8'd0;
                    burst.res[0]    = tx_res(LINK_CONNECT);
                    burst.count     = CNT_W'(1);
                    phase_next      = PH_WAIT_CONNECT;
                    timer_next      = cfg.connect_timeout;
                end
                OP_PAYLOAD: begin
                    if (phase_reg == PH_DATA) begin
                        burst.res[0]   = tx_res(item.payload_byte);
                        burst.count    = CNT_W'(1);
                        chunk_xor_next = xor_inc;
                        image_xor_next = image_xor_reg ^ item.payload_byte;
                        chunk_cnt_next = cnt_inc;
                        if (remaining_reg != 32'd0) begin
                            remaining_next = remaining_reg - 32'd1;
                        end
                        // chunk complete: append its checksum and wait
                        if (cnt_inc >= frame_size_reg) begin
                            burst.res[1] = tx_res(xor_inc);
                            burst.count  = CNT_W'(2);
                            phase_next   = PH_WAIT_CHUNK;
                            timer_next   = cfg.packet_timeout;
                        end
                    end
                end
                OP_REPLY: begin
                    if (waiting) begin
                        if (item.reply_byte != cfg.ack_code) begin
                            burst.res[0] = status_res(ST_FAILED, stage);
                            burst.count  = CNT_W'(1);
                            phase_next   = PH_FAILED;
                            timer_next   = 16'd0;
                        end else begin
                            case (phase_reg)
                                PH_WAIT_CONNECT: begin
                                    burst.res[0] = tx_res(LINK_INFO);
                                    burst.res[1] = tx_res(remaining_reg[31:24]);
                                    burst.res[2] = tx_res(remaining_reg[23:16]);
                                    burst.res[3] = tx_res(remaining_reg[15:8]);
                                    burst.res[4] = tx_res(remaining_reg[7:0]);
                                    burst.count  = CNT_W'(5);
                                    phase_next   = PH_WAIT_ERASE;
                                    timer_next   = cfg.erase_timeout;
                                end
                                PH_WAIT_ERASE, PH_WAIT_CHUNK: begin
                                    burst.count = CNT_W'(2);
                                    if (remaining_reg == 32'd0) begin
                                        burst.res[0] = tx_res(LINK_END);
                                        burst.res[1] = tx_res(image_xor_reg);
                                        phase_next   = PH_WAIT_END;
                                        timer_next   = cfg.end_timeout;
                                    end else begin
                                        frame_size_next = frame_len;
                                        chunk_cnt_next  = 8'd0;
                                        chunk_xor_next  = 8'd0;
                                        burst.res[0]    = tx_res(LINK_DATA);
                                        burst.res[1]    = tx_res(frame_len);
                                        phase_next      = PH_DATA;
                                        timer_next      = 16'd0;
                                    end
                                end
                                default: begin
                                    burst.res[0] = status_res(ST_SUCCESS, STG_NONE);
                                    burst.count  = CNT_W'(1);
                                    phase_next   = PH_DONE;
                                    timer_next   = 16'd0;
                                end
                            endcase
                        end
                    end
                end
                default: begin
                    if (waiting) begin
                        if (timer_reg <= 16'd1) begin
                            burst.res[0] = status_res(ST_FAILED, stage);
                            burst.count  = CNT_W'(1);
                            phase_next   = PH_FAILED;
                            timer_next   = 16'd0;
                        end else begin
                            timer_next = timer_reg - 16'd1;
                        end
                    end
                end
            endcase
        end

        for (int i = 0; i < MAX_RESULTS; i++) begin
            burst.res[i].last = (burst.count == CNT_W'(i + 1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            remaining_reg  <= 32'd0;
            frame_size_reg <= 8'd0;
            chunk_cnt_reg  <= 8'd0;
            chunk_xor_reg  <= 8'd0;
            image_xor_reg  <= 8'd0;
            timer_reg      <= 16'd0;
        end else begin
            phase_reg      <= phase_next;
            remaining_reg  <= remaining_next;
            frame_size_reg <= frame_size_next;
            chunk_cnt_reg  <= chunk_cnt_next;
            chunk_xor_reg  <= chunk_xor_next;
            image_xor_reg  <= image_xor_next;
            timer_reg      <= timer_next;
        end
    end

endmodule

// File: src/ufu_burst.sv
// Result register: holds one item's burst and hands it out one transfer a cycle while m_ready is high.
// Depends on ufu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ufu_burst (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  ufu_pkg::burst_t burst,
    output logic            space,
    output logic            m_valid,
    input  logic            m_ready,
    output ufu_pkg::out_t   m_data
);
    import ufu_pkg::*;

    out_t             res_reg [MAX_RESULTS];
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             take;
    logic             fill;

    assign m_valid = (rem_reg != '0);
    assign take    = m_valid && m_ready;
    // room when empty, or when the final transfer leaves this cycle
    assign space   = !m_valid || (m_ready && rem_reg == CNT_W'(1));
    assign fill    = load && (burst.count != '0);
    assign m_data  = res_reg[pos_reg];

    always_comb begin
        rem_next = rem_reg;
        pos_next = pos_reg;
        if (fill) begin
            rem_next = burst.count;
            pos_next = '0;
        end else if (take) begin
            rem_next = rem_reg - CNT_W'(1);
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            pos_reg <= '0;
        end else begin
            rem_reg <= rem_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fill) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                res_reg[i] <= burst.res[i];
            end
        end
    end

    `ASSERT_NOW(a_no_overwrite, aclk, aresetn, fill, space, "burst loaded over pending results")
    `ASSERT_NOW(a_last_marks_end, aclk, aresetn, m_valid, (m_data.last == (rem_reg == CNT_W'(1))), "last flag out of step with burst end")
    `ASSERT_NEXT(a_load_count, aclk, aresetn, fill, (rem_reg == $past(burst.count) && pos_reg == '0), "burst count not captured")

endmodule

// File: src/uart_firmware_upload_sender.sv
// Top level of the firmware upload sender: configuration registers, core, result stage.
// Depends on ufu_pkg, ufu_core and ufu_burst.
//
//   channel  | signals                          | transfer when
//   ---------+----------------------------------+---------------------------
//   input    | s_valid, s_ready, s_data (in_t)  | s_valid && s_ready
//   result   | m_valid, m_ready, m_data (out_t) | m_valid && m_ready
//   config   | cfg_wr_en, cfg_index, cfg_wr_data| cfg_wr_en
//
// An item is processed in the cycle it is accepted; its 0 to 5 results are registered
// and offered from the next cycle, leaving one per cycle while m_ready is high. A new item is taken
// whenever the result register is empty or hands out its final result, so items
// giving at most one result run at one per cycle while m_ready is high; an item with more
// results holds off input until its final result leaves. Reset is synchronous, active low, with no clearing pass.
`timescale 1ns / 1ps

module uart_firmware_upload_sender #(
    parameter int CHUNK_SIZE = 128
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ufu_pkg::in_t                      s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ufu_pkg::out_t                     m_data,
    input  logic                              cfg_wr_en,
    input  logic [ufu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ufu_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import ufu_pkg::*;

    cfg_t   cfg_reg;
    burst_t burst;
    logic   accept;
    logic   space;

    assign s_ready = space;
    assign accept  = s_valid && space;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ack_code        <= 8'd121;
            cfg_reg.connect_timeout <= 16'd2000;
            cfg_reg.erase_timeout   <= 16'd5000;
            cfg_reg.packet_timeout  <= 16'd500;
            cfg_reg.end_timeout     <= 16'd2000;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ACK_CODE:        cfg_reg.ack_code        <= cfg_wr_data[7:0];
                REG_CONNECT_TIMEOUT: cfg_reg.connect_timeout <= cfg_wr_data;
                REG_ERASE_TIMEOUT:   cfg_reg.erase_timeout   <= cfg_wr_data;
                REG_PACKET_TIMEOUT:  cfg_reg.packet_timeout  <= cfg_wr_data;
                REG_END_TIMEOUT:     cfg_reg.end_timeout     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    ufu_core #(
        .CHUNK_SIZE(CHUNK_SIZE)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_data),
        .cfg     (cfg_reg),
        .burst   (burst)
    );

    ufu_burst u_burst (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (accept),
        .burst   (burst),
        .space   (space),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: dv/tb_uart_firmware_upload_sender.sv
// Self-checking testbench for uart_firmware_upload_sender: predicts the link bytes and status.
// Stimulus is directed cases followed by random upload sessions under several stall mixes.
// Depends on ufu_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_uart_firmware_upload_sender;
    import ufu_pkg::*;

    localparam int CHUNK_BYTES = 128;
    localparam int QUIET_LIMIT = 4000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    uart_firmware_upload_sender #(.CHUNK_SIZE(CHUNK_BYTES)) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // pending stimulus and expected link results
    in_t  upload_items[$];
    out_t expected_link_q[$];
    out_t item_results[$];
    int unsigned items_queued = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic in_taken = 1'b0;

    // predictor copy of configuration and state
    logic [7:0]  ack_cfg = 8'd121;
    logic [15:0] connect_to = 16'd2000;
    logic [15:0] erase_to = 16'd5000;
    logic [15:0] packet_to = 16'd500;
    logic [15:0] end_to = 16'd2000;
    phase_t      ph = PH_IDLE;
    logic [31:0] bytes_left = '0;
    logic [7:0]  frame_size = '0;
    logic [7:0]  chunk_cnt = '0;
    logic [7:0]  chunk_sum = '0;
    logic [7:0]  image_sum = '0;
    logic [15:0] wait_ticks = '0;

    int unsigned errors = 0;
    int unsigned items_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned uploads_ok = 0;
    int unsigned uploads_failed = 0;
    int unsigned quiet_cycles = 0;

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    function automatic out_t link_byte(input logic [7:0] b);
        out_t r;
        r.tx_valid   = 1'b1;
        r.tx_byte    = b;
        r.status     = ST_RUNNING;
        r.fail_stage = STG_NONE;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic out_t outcome(input logic [1:0] st, input logic [2:0] stg);
        out_t r;
        r.tx_valid   = 1'b0;
        r.tx_byte    = 8'd0;
        r.status     = st;
        r.fail_stage = stg;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic bit awaiting_reply();
        return ph == PH_WAIT_CONNECT || ph == PH_WAIT_ERASE ||
               ph == PH_WAIT_CHUNK || ph == PH_WAIT_END;
    endfunction

    function automatic void abort_upload();
        logic [2:0] stg;
        case (ph)
            PH_WAIT_CONNECT: stg = STG_CONNECT;
            PH_WAIT_ERASE:   stg = STG_ERASE;
            PH_WAIT_CHUNK:   stg = STG_CHUNK;
            PH_WAIT_END:     stg = STG_END;
            default:         stg = STG_NONE;
        endcase
        ph = PH_FAILED;
        wait_ticks = '0;
        uploads_failed++;
        item_results.push_back(outcome(ST_FAILED, stg));
    endfunction

    // open the next chunk, or the end sequence once the image is out
    function automatic void open_frame();
        if (bytes_left == 0) begin
            item_results.push_back(link_byte(LINK_END));
            item_results.push_back(link_byte(image_sum));
            ph = PH_WAIT_END;
            wait_ticks = end_to;
        end else begin
            frame_size = (bytes_left > CHUNK_BYTES) ? 8'(CHUNK_BYTES) : bytes_left[7:0];
            chunk_cnt = '0;
            chunk_sum = '0;
            item_results.push_back(link_byte(LINK_DATA));
            item_results.push_back(link_byte(frame_size));
            ph = PH_DATA;
            wait_ticks = '0;
        end
    endfunction

    function automatic void advance_sender(input in_t it);
        case (it.opcode)
            OP_START: begin
                bytes_left = it.image_length;
                frame_size = '0;
                chunk_cnt = '0;
                chunk_sum = '0;
                image_sum = '0;
                item_results.push_back(link_byte(LINK_CONNECT));
                ph = PH_WAIT_CONNECT;
                wait_ticks = connect_to;
            end
            OP_PAYLOAD: begin
                if (ph == PH_DATA) begin
                    item_results.push_back(link_byte(it.payload_byte));
                    chunk_sum ^= it.payload_byte;
                    image_sum ^= it.payload_byte;
                    chunk_cnt = chunk_cnt + 8'd1;
                    if (bytes_left != 0)
                        bytes_left = bytes_left - 1;
                    if (chunk_cnt >= frame_size) begin
                        item_results.push_back(link_byte(chunk_sum));
                        ph = PH_WAIT_CHUNK;
                        wait_ticks = packet_to;
                    end
                end
            end
            OP_REPLY: begin
                if (awaiting_reply()) begin
                    if (it.reply_byte != ack_cfg) begin
                        abort_upload();
                    end else begin
                        case (ph)
                            PH_WAIT_CONNECT: begin
                                item_results.push_back(link_byte(LINK_INFO));
                                item_results.push_back(link_byte(bytes_left[31:24]));
                                item_results.push_back(link_byte(bytes_left[23:16]));
                                item_results.push_back(link_byte(bytes_left[15:8]));
                                item_results.push_back(link_byte(bytes_left[7:0]));
                                ph = PH_WAIT_ERASE;
                                wait_ticks = erase_to;
                            end
                            PH_WAIT_ERASE, PH_WAIT_CHUNK: begin
                                open_frame();
                            end
                            default: begin
                                ph = PH_DONE;
                                wait_ticks = '0;
                                uploads_ok++;
                                item_results.push_back(outcome(ST_SUCCESS, STG_NONE));
                            end
                        endcase
                    end
                end
            end
            default: begin
                if (awaiting_reply()) begin
                    if (wait_ticks <= 16'd1)
                        abort_upload();
                    else
                        wait_ticks = wait_ticks - 16'd1;
                end
            end
        endcase
        if (item_results.size() != 0)
            item_results[item_results.size() - 1].last = 1'b1;
        while (item_results.size() != 0)
            expected_link_q.push_back(item_results.pop_front());
    endfunction

    // stimulus builders: fields an opcode does not use get random values
    function automatic void push_item(input logic [1:0] op, input logic [31:0] len,
                                      input logic [7:0] pay, input logic [7:0] rep);
        in_t it;
        it.opcode       = op;
        it.image_length = len;
        it.payload_byte = pay;
        it.reply_byte   = rep;
        upload_items.push_back(it);
        items_queued++;
    endfunction

    function automatic void push_start(input logic [31:0] len);
        push_item(OP_START, len, 8'($urandom), 8'($urandom));
    endfunction

    function automatic void push_payload(input logic [7:0] b);
        push_item(OP_PAYLOAD, $urandom, b, 8'($urandom));
    endfunction

    function automatic void push_reply(input logic [7:0] b);
        push_item(OP_REPLY, $urandom, 8'($urandom), b);
    endfunction

    function automatic void push_tick();
        push_item(OP_TICK, $urandom, 8'($urandom), 8'($urandom));
    endfunction

    // sometimes up to four ticks, then an acknowledge or a bad reply; 0 when the session is over
    function automatic bit queue_ack_wait(input logic [15:0] limit);
        int unsigned ticks;
        ticks = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
        for (int i = 0; i < ticks; i++)
            push_tick();
        if (ticks != 0 && ticks >= limit)
            return 1'b0;
        if ($urandom_range(0, 99) < 6) begin
            push_reply(ack_cfg ^ 8'($urandom_range(1, 255)));
            return 1'b0;
        end
        push_reply(ack_cfg);
        return 1'b1;
    endfunction

    function automatic logic [31:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 72)
            return $urandom_range(0, 6);
        else if (roll < 92)
            return $urandom_range(7, 24);
        else if (roll < 95)
            return $urandom_range(CHUNK_BYTES - 1, CHUNK_BYTES + 2);
        return $urandom;
    endfunction

    function automatic void queue_session(input logic [31:0] len);
        int unsigned sent;
        int unsigned chunk;
        int unsigned cut;
        // drop in a little noise ahead of the session now and then
        if ($urandom_range(0, 9) == 0)
            push_item(2'($urandom_range(0, 3)), $urandom, 8'($urandom), 8'($urandom));
        push_start(len);
        if (!queue_ack_wait(connect_to))
            return;
        if (!queue_ack_wait(erase_to))
            return;
        // huge images are abandoned a few bytes in by the next start
        cut = (len > 300) ? $urandom_range(1, 5) : 0;
        sent = 0;
        while (sent < len) begin
            chunk = (len - sent > CHUNK_BYTES) ? CHUNK_BYTES : len - sent;
            for (int k = 0; k < chunk; k++) begin
                push_payload(8'($urandom));
                if ($urandom_range(0, 19) == 0)
                    push_tick();
                sent++;
                if (cut != 0 && sent >= cut)
                    return;
            end
            if (!queue_ack_wait(packet_to))
                return;
        end
        void'(queue_ack_wait(end_to));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_ACK_CODE:        ack_cfg = val[7:0];
            REG_CONNECT_TIMEOUT: connect_to = val;
            REG_ERASE_TIMEOUT:   erase_to = val;
            REG_PACKET_TIMEOUT:  packet_to = val;
            REG_END_TIMEOUT:     end_to = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [7:0] ack, input logic [15:0] con,
                                  input logic [15:0] era, input logic [15:0] pkt,
                                  input logic [15:0] fin);
        // upper byte of the ack write is don't-care
        write_reg(REG_ACK_CODE, {8'($urandom), ack});
        write_reg(REG_CONNECT_TIMEOUT, con);
        write_reg(REG_ERASE_TIMEOUT, era);
        write_reg(REG_PACKET_TIMEOUT, pkt);
        write_reg(REG_END_TIMEOUT, fin);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] pick_timeout();
        return ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 4))
                                           : 16'($urandom_range(1, 65535));
    endfunction

    task automatic wait_idle();
        while (upload_items.size() != 0 || s_valid || expected_link_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // driver: present the next transfer at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (upload_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                s_data  <= upload_items.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: predict on input transfers, check result transfers
    always @(posedge aclk) begin
        out_t exp_r;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            items_accepted++;
            advance_sender(s_data);
        end
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (expected_link_q.size() == 0) begin
                note_error($sformatf("%0t: unexpected result valid=%0b byte=%h status=%0d stage=%0d last=%0b",
                    $time, m_data.tx_valid, m_data.tx_byte, m_data.status,
                    m_data.fail_stage, m_data.last));
            end else begin
                exp_r = expected_link_q.pop_front();
                if (m_data.tx_valid !== exp_r.tx_valid || m_data.tx_byte !== exp_r.tx_byte ||
                    m_data.status !== exp_r.status || m_data.fail_stage !== exp_r.fail_stage ||
                    m_data.last !== exp_r.last)
                    note_error($sformatf(
                        "%0t: mismatch exp valid=%0b byte=%h status=%0d stage=%0d last=%0b, got valid=%0b byte=%h status=%0d stage=%0d last=%0b",
                        $time, exp_r.tx_valid, exp_r.tx_byte, exp_r.status, exp_r.fail_stage,
                        exp_r.last, m_data.tx_valid, m_data.tx_byte, m_data.status,
                        m_data.fail_stage, m_data.last));
            end
        end
    end

    // watchdog on cycles with no transfer of any kind
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int unsigned half;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: zero-length image, bad replies, reply during data phase
        push_start(32'd0);
        push_tick();
        push_reply(8'd121);
        push_payload(8'h5A);
        push_reply(8'd121);
        push_reply(8'd121);
        push_tick();
        push_start(32'hFFFF_FFFF);
        push_reply(8'h00);
        push_start(32'd2);
        push_reply(8'd121);
        push_reply(8'd121);
        push_payload(8'hFF);
        push_reply(8'd121);
        push_payload(8'h00);
        push_reply(8'd121);
        push_reply(8'hFF);
        push_start(32'h8000_0081);
        push_reply(8'd121);
        push_reply(8'h86);
        wait_idle();

        // zero and one tick timeouts expire on the first tick, a two tick one on the second
        apply_settings(8'h00, 16'd0, 16'd1, 16'd2, 16'hFFFF);
        push_start(32'd1);
        push_tick();
        push_start(32'd1);
        push_reply(8'h00);
        push_tick();
        push_start(32'd1);
        push_reply(8'h00);
        push_reply(8'h00);
        push_payload(8'h3C);
        push_tick();
        push_tick();
        push_start(32'd0);
        push_reply(8'h00);
        push_reply(8'h00);
        push_tick();
        push_reply(8'h00);
        wait_idle();

        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin sender_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            if (mode == 0)
                apply_settings(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            else
                apply_settings(8'($urandom), pick_timeout(), pick_timeout(),
                               pick_timeout(), pick_timeout());
            // one image that spans a full chunk and spills into a second
            if (mode == 0)
                queue_session(32'(CHUNK_BYTES + 1));
            for (int b = 0; b < 2; b++) begin
                half = items_queued + 20;
                while (items_queued < half)
                    queue_session(pick_length());
                // hold off new transfers until the block has drained
                wait_idle();
            end
        end

        wait_idle();
        $display("covered %0d input transfers and %0d result transfers", items_accepted,
                 results_checked);
        $display("uploads completed: %0d, uploads failed: %0d, mismatches: %0d",
                 uploads_ok, uploads_failed, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/ufu_pkg.sv
src/ufu_core.sv
src/ufu_burst.sv
src/uart_firmware_upload_sender.sv
dv/tb_uart_firmware_upload_sender.sv
